[hdl/htcm_pkg.sv]
// Constants, colour table and band helper functions for the height to colour map.
package htcm_pkg;

   localparam int HEIGHT_W              = 20;
   localparam int OFFSET_W              = 16;
   localparam int CHAN_W                = 8;
   localparam int DEF_HEIGHT_FRAC_BITS  = 4;
   localparam int DEF_COLOR_BITS        = 8;
   localparam int OFFSET_RESET          = 2400;

   localparam int NUM_BP   = 8;
   localparam int NUM_SEG  = NUM_BP + 1;
   localparam int SEG_W    = $clog2(NUM_SEG);
   localparam int NUM_CH   = 3;

   // Colours are held in units of 4e-8, so full scale is this value.
   localparam int COL_UNIT = 25000000;
   localparam int COL_W    = 25;
   // Bits for the longest band in centimetres and for a breakpoint with its sign.
   localparam int LEN_W    = 20;
   localparam int BP_W     = 21;

   localparam int BP_CM [NUM_BP] = '{
      -900000, -852507, 18900, 19000, 152770, 421900, 449604, 600000
   };

   localparam int BP_COL [NUM_BP][NUM_CH] = '{
      '{       0,        0,  5000000},
      '{       0,        0, 25000000},
      '{       0, 25000000, 25000000},
      '{       0, 10000000,  5000000},
      '{23823525, 21176475, 10392150},
      '{10489425,  4606325,   162127},
      '{24585325, 23902500, 23893725},
      '{25000000, 25000000, 25000000}
   };

   // Segment 0 lies below the first breakpoint and the last segment above the last one.
   function automatic int seg_len(input int s);
      if (s == 0 || s >= NUM_BP) begin
         return 1;
      end
      return BP_CM[s] - BP_CM[s - 1];
   endfunction

   function automatic int seg_lo(input int s, input int c);
      if (s == 0) begin
         return BP_COL[0][c];
      end
      return BP_COL[s - 1][c];
   endfunction

   function automatic int seg_hi(input int s, input int c);
      if (s == 0) begin
         return BP_COL[0][c];
      end
      if (s >= NUM_BP) begin
         return BP_COL[NUM_BP - 1][c];
      end
      return BP_COL[s][c];
   endfunction

endpackage

[hdl/height_to_color_map.sv]
// Height to colour map: band search, interpolation and rounding pipeline.
//
//  Channel   Ports                                   Handshake
//  request   start, busy, req_height                 taken when start is high and busy low
//  result    rsp_strobe, rsp_red/green/blue          shown for one cycle, no back-pressure
//  config    csr_wr_en, csr_wr_data                  height_offset written when enable high
//
// A transaction may be started on every cycle.
// The stages are offset, scaling, band search, product, sum, quotient estimate, correction
// product and final compare, which together round each channel exactly.
// Synchronous reset empties the pipeline and sets the offset to 150 m.
// Busy stays low, and the receiver cannot stall the result.
module height_to_color_map #(
   parameter int HEIGHT_FRAC_BITS = htcm_pkg::DEF_HEIGHT_FRAC_BITS,
   parameter int COLOR_BITS       = htcm_pkg::DEF_COLOR_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [htcm_pkg::HEIGHT_W-1:0]  req_height,
   input  logic                                  csr_wr_en,
   input  logic signed [htcm_pkg::OFFSET_W-1:0]  csr_wr_data,
   output logic                                  rsp_strobe,
   output logic        [htcm_pkg::CHAN_W-1:0]    rsp_red,
   output logic        [htcm_pkg::CHAN_W-1:0]    rsp_green,
   output logic        [htcm_pkg::CHAN_W-1:0]    rsp_blue
);
   import htcm_pkg::*;

   localparam int S       = 2 ** COLOR_BITS - 1;
   localparam int HSW     = HEIGHT_W + 1;
   localparam int HCW     = HSW + 7;
   localparam int CW      = ((BP_W + HEIGHT_FRAC_BITS > HCW) ? BP_W + HEIGHT_FRAC_BITS : HCW) + 1;
   localparam int NUMW    = LEN_W + HEIGHT_FRAC_BITS;
   localparam int DCW     = COL_W + 1;
   localparam int PW      = DCW + NUMW + 1;
   localparam int NW      = COL_W + 1 + LEN_W + HEIGHT_FRAC_BITS + COLOR_BITS;
   localparam int SW      = NW + 2;
   localparam int LATENCY = 8;
   localparam int SHW     = 6;
   localparam int NHW     = COLOR_BITS + 4;
   localparam int RW      = COLOR_BITS + 4;
   localparam int EW      = COLOR_BITS + 6;
   localparam int QW      = COLOR_BITS + 1;
   localparam int QLW     = QW + LEN_W;

   function automatic int bit_len(input longint unsigned v);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) begin
         if ((v >> i) != 0) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

   function automatic longint unsigned recip_floor(input longint unsigned d, input int e);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 1;
      for (int i = 0; i < e; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q + 1;
         end
      end
      return q;
   endfunction

   logic signed [DCW-1:0]    dc_tab  [NUM_SEG][NUM_CH];
   logic        [NW-1:0]     cc_tab  [NUM_SEG][NUM_CH];
   logic        [NW-1:0]     dn_tab  [NUM_SEG];
   logic        [LEN_W-1:0]  len_tab [NUM_SEG];
   logic        [SHW-1:0]    sh_tab  [NUM_SEG];
   logic        [RW-1:0]     rcp_tab [NUM_SEG];
   logic signed [CW-1:0]     thr_tab [NUM_BP];

   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic        [LATENCY-1:0]  pipe_vld_ff, pipe_vld_in;
   logic                       accept;

   logic signed [HSW-1:0]    sum_ff, sum_in;
   logic signed [CW-1:0]     hc_ff, hc_in;
   logic signed [CW-1:0]     diff [NUM_BP];
   logic        [SEG_W-1:0]  seg_c_ff, seg_c_in;
   logic        [NUMW-1:0]   num_ff, num_in;
   logic        [SEG_W-1:0]  seg_d_ff;
   logic signed [PW-1:0]     prod_ff [NUM_CH];
   logic signed [PW-1:0]     prod_in [NUM_CH];
   logic signed [SW-1:0]     nsum [NUM_CH];
   logic        [NW-1:0]     n_in [NUM_CH];

   logic        [SEG_W-1:0]      seg_n_ff, seg_e_ff;
   logic        [NW-1:0]         n_ff    [NUM_CH];
   logic        [NW-1:0]         n_sh    [NUM_CH];
   logic        [NHW+RW-1:0]     est     [NUM_CH];
   logic        [COLOR_BITS-1:0] qe_in   [NUM_CH];
   logic        [COLOR_BITS-1:0] qe_ff   [NUM_CH];
   logic        [NW-1:0]         n_e_ff  [NUM_CH];
   logic        [QW-1:0]         q1      [NUM_CH];
   logic        [QLW-1:0]        ql_in   [NUM_CH];
   logic        [QLW-1:0]        ql_ff   [NUM_CH];
   logic        [COLOR_BITS-1:0] qe_f_ff [NUM_CH];
   logic        [NW-1:0]         n_f_ff  [NUM_CH];
   logic        [NW-1:0]         qd      [NUM_CH];
   logic        [COLOR_BITS-1:0] q_in    [NUM_CH];
   logic        [COLOR_BITS-1:0] q_ff    [NUM_CH];

   // Each band divisor gets a shift that leaves it four bits long and a short reciprocal.
   always_comb begin
      for (int s = 0; s < NUM_SEG; s++) begin
         dn_tab[s]  = (NW'(2 * COL_UNIT) * NW'(seg_len(s))) << HEIGHT_FRAC_BITS;
         len_tab[s] = LEN_W'(seg_len(s));
         sh_tab[s]  = SHW'(bit_len(64'(dn_tab[s])) - 4);
         rcp_tab[s] = RW'(recip_floor(64'(dn_tab[s]), EW + bit_len(64'(dn_tab[s])) - 4));
         for (int c = 0; c < NUM_CH; c++) begin
            dc_tab[s][c] = DCW'(seg_hi(s, c) - seg_lo(s, c));
            cc_tab[s][c] = (NW'(seg_len(s)) *
                            (NW'(2 * S) * NW'(seg_lo(s, c)) + NW'(COL_UNIT)))
                           << HEIGHT_FRAC_BITS;
         end
      end
      for (int k = 0; k < NUM_BP; k++) begin
         thr_tab[k] = CW'(BP_CM[k]) <<< HEIGHT_FRAC_BITS;
      end
   end

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign offset_in   = csr_wr_en ? csr_wr_data : offset_ff;
   assign pipe_vld_in = {pipe_vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= OFFSET_W'(OFFSET_RESET);
         pipe_vld_ff <= '0;
      end else begin
         offset_ff   <= offset_in;
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   assign sum_in = HSW'(req_height) + HSW'(offset_ff);
   assign hc_in  = (CW'(sum_ff) <<< 6) + (CW'(sum_ff) <<< 5) + (CW'(sum_ff) <<< 2);

   // The sign of each difference gives the comparison, and the difference itself the band offset.
   always_comb begin
      seg_c_in = '0;
      num_in   = '0;
      for (int k = 0; k < NUM_BP; k++) begin
         diff[k] = hc_ff - thr_tab[k];
         if (!diff[k][CW-1]) begin
            seg_c_in = SEG_W'(k + 1);
            num_in   = diff[k][NUMW-1:0];
         end
      end
      if (seg_c_in == SEG_W'(NUM_BP)) begin
         num_in = '0;
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         prod_in[c] = dc_tab[seg_c_ff][c] * $signed({1'b0, num_ff});
      end
   end

   // Rounded channel is floor((2S(ca*den + dc*num) + U*den) / (2U*den)).
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         nsum[c] = $signed({2'b00, cc_tab[seg_d_ff][c]})
                   + (SW'(prod_ff[c]) <<< (COLOR_BITS + 1))
                   - (SW'(prod_ff[c]) <<< 1);
         n_in[c] = nsum[c][NW-1:0];
      end
   end

   // The estimate is the true quotient or one below it, and the compare settles which.
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         n_sh[c]  = n_ff[c] >> sh_tab[seg_n_ff];
         est[c]   = n_sh[c][NHW-1:0] * rcp_tab[seg_n_ff];
         qe_in[c] = est[c][EW +: COLOR_BITS];
         q1[c]    = {1'b0, qe_ff[c]} + QW'(1);
         ql_in[c] = QLW'(q1[c]) * QLW'(len_tab[seg_e_ff]);
         qd[c]    = (NW'(ql_ff[c]) * NW'(2 * COL_UNIT)) << HEIGHT_FRAC_BITS;
         q_in[c]  = qe_f_ff[c] + COLOR_BITS'(n_f_ff[c] >= qd[c]);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      hc_ff    <= hc_in;
      seg_c_ff <= seg_c_in;
      num_ff   <= num_in;
      seg_d_ff <= seg_c_ff;
      seg_n_ff <= seg_d_ff;
      seg_e_ff <= seg_n_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         prod_ff[c] <= prod_in[c];
         n_ff[c]    <= n_in[c];
         qe_ff[c]   <= qe_in[c];
         n_e_ff[c]  <= n_ff[c];
         ql_ff[c]   <= ql_in[c];
         qe_f_ff[c] <= qe_ff[c];
         n_f_ff[c]  <= n_e_ff[c];
         q_ff[c]    <= q_in[c];
      end
   end

   assign rsp_strobe = pipe_vld_ff[LATENCY-1];
   assign rsp_red    = CHAN_W'(q_ff[0]);
   assign rsp_green  = CHAN_W'(q_ff[1]);
   assign rsp_blue   = CHAN_W'(q_ff[2]);

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted transaction did not produce a result on time");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching transaction");

   a_quot_range : assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff[4] |->
         (n_ff[0] < ({1'b0, dn_tab[seg_n_ff]} << COLOR_BITS)) &&
         (n_ff[1] < ({1'b0, dn_tab[seg_n_ff]} << COLOR_BITS)) &&
         (n_ff[2] < ({1'b0, dn_tab[seg_n_ff]} << COLOR_BITS)))
      else $error("dividend exceeds the quotient range of the rounding stage");
`endif

endmodule

[dv/height_to_color_map_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for height_to_color_map with a scoreboard class and a colour predictor.
module height_to_color_map_tb;

   import htcm_pkg::*;

   localparam int FRAC_BITS  = DEF_HEIGHT_FRAC_BITS;
   localparam int CBITS      = DEF_COLOR_BITS;
   localparam int LATENCY    = 8;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 212;
   localparam longint SCALE  = 64'sd1 << FRAC_BITS;
   localparam longint unsigned COLOUR_UNIT = 64'd100000000;

   localparam longint BREAK_CM [8] = '{
      -900000, -852507, 18900, 19000, 152770, 421900, 449604, 600000
   };

   localparam longint BREAK_COLOUR [8][3] = '{
      '{        0,         0,  20000000},
      '{        0,         0, 100000000},
      '{        0, 100000000, 100000000},
      '{        0,  40000000,  20000000},
      '{ 95294100,  84705900,  41568600},
      '{ 41957700,  18425300,    648508},
      '{ 98341300,  95610000,  95574900},
      '{100000000, 100000000, 100000000}
   };

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

   class colour_scoreboard_type;
      longint      offset;
      colour_type  expected_q[$];
      int unsigned failures;

      function new();
         offset   = OFFSET_RESET;
         failures = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // round(full * (ca + (cb - ca) * num / den) / 1e8), ties rounding up
      function logic [CHAN_W-1:0] mix_channel(longint ca, longint cb, longint num, longint den);
         longint unsigned full, un, ud, q, r, x, a, b, d, rem, v;
         longint n;
         full = (64'd1 << CBITS) - 1;
         n = ca * den + (cb - ca) * num;
         if (n < 0) begin
            n = 0;
         end
         un  = n;
         ud  = den;
         q   = un / ud;
         r   = un % ud;
         x   = full * q;
         a   = x / COLOUR_UNIT;
         b   = x % COLOUR_UNIT;
         d   = COLOUR_UNIT * ud;
         rem = b * ud + full * r;
         v   = a + (2 * rem + d) / (2 * d);
         if (v > full) begin
            v = full;
         end
         return v[CHAN_W-1:0];
      endfunction

      function colour_type map_height(logic signed [HEIGHT_W-1:0] height);
         longint h, hc, num, den;
         int band;
         logic [CHAN_W-1:0] chan [3];
         h  = longint'(height) + offset;
         hc = h * 100;
         if (hc < BREAK_CM[0] * SCALE) begin
            for (int c = 0; c < 3; c++) begin
               chan[c] = mix_channel(BREAK_COLOUR[0][c], BREAK_COLOUR[0][c], 0, 1);
            end
         end else if (hc >= BREAK_CM[7] * SCALE) begin
            for (int c = 0; c < 3; c++) begin
               chan[c] = mix_channel(BREAK_COLOUR[7][c], BREAK_COLOUR[7][c], 0, 1);
            end
         end else begin
            band = 0;
            for (int k = 1; k < 7; k++) begin
               if (hc >= BREAK_CM[k] * SCALE) begin
                  band = k;
               end
            end
            num = hc - BREAK_CM[band] * SCALE;
            den = (BREAK_CM[band + 1] - BREAK_CM[band]) * SCALE;
            for (int c = 0; c < 3; c++) begin
               chan[c] = mix_channel(BREAK_COLOUR[band][c], BREAK_COLOUR[band + 1][c], num, den);
            end
         end
         return {chan[0], chan[1], chan[2]};
      endfunction

      function void note_height(logic signed [HEIGHT_W-1:0] height);
         expected_q.push_back(map_height(height));
      endfunction

      function void check_colour(colour_type got);
         colour_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                     got.red, got.green, got.blue);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got.red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            failures++;
         end
         if (got.green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            failures++;
         end
         if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            failures++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [HEIGHT_W-1:0]  req_height;
   logic                        csr_wr_en;
   logic signed [OFFSET_W-1:0]  csr_wr_data;
   logic                        rsp_strobe;
   logic        [CHAN_W-1:0]    rsp_red;
   logic        [CHAN_W-1:0]    rsp_green;
   logic        [CHAN_W-1:0]    rsp_blue;

   colour_scoreboard_type sb;
   bit                    steady;

   height_to_color_map #(
      .HEIGHT_FRAC_BITS(FRAC_BITS),
      .COLOR_BITS(CBITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_height(req_height),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_strobe(rsp_strobe),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_colour({rsp_red, rsp_green, rsp_blue});
      end
   end

   task automatic send_height(logic signed [HEIGHT_W-1:0] h);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_height <= h;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_height(h);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_offset(logic signed [OFFSET_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.offset = longint'(value);
   endtask

   function automatic logic signed [HEIGHT_W-1:0] clamp_height(longint v);
      if (v < -(64'sd1 << (HEIGHT_W - 1))) begin
         v = -(64'sd1 << (HEIGHT_W - 1));
      end
      if (v > (64'sd1 << (HEIGHT_W - 1)) - 1) begin
         v = (64'sd1 << (HEIGHT_W - 1)) - 1;
      end
      return v[HEIGHT_W-1:0];
   endfunction

   // Mostly heights that land inside the colour bands, some near breakpoints, some anywhere.
   function automatic logic signed [HEIGHT_W-1:0] random_height();
      int mode;
      longint target;
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
         return HEIGHT_W'($urandom);
      end else if (mode < 4) begin
         target = BREAK_CM[$urandom_range(0, 7)] * SCALE / 100
                  + longint'($urandom_range(0, 8)) - 4;
      end else begin
         target = longint'($urandom_range(0, 245000)) - 146000;
      end
      return clamp_height(target - sb.offset);
   endfunction

   initial begin
      longint t;
      sb = new();
      steady      = 1'b0;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_height <= '0;
      csr_wr_en  <= 1'b0;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of the offset: both sides of every breakpoint and the height extremes.
      for (int k = 0; k < 8; k++) begin
         t = BREAK_CM[k] * SCALE / 100 - sb.offset;
         for (int j = -1; j <= 1; j++) begin
            send_height(clamp_height(t + j));
         end
      end
      send_height(HEIGHT_W'(-(1 << (HEIGHT_W - 1))));
      send_height(HEIGHT_W'((1 << (HEIGHT_W - 1)) - 1));
      send_height(HEIGHT_W'(0));
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: write_offset(OFFSET_W'(-(1 << (OFFSET_W - 1))));
            1: write_offset(OFFSET_W'((1 << (OFFSET_W - 1)) - 1));
            2: write_offset(OFFSET_W'(0));
            default: write_offset(OFFSET_W'($urandom));
         endcase
         send_height(HEIGHT_W'(-(1 << (HEIGHT_W - 1))));
         send_height(HEIGHT_W'((1 << (HEIGHT_W - 1)) - 1));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) begin
               steady = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 99) == 0) begin
               drain();
            end
            send_height(random_height());
         end
         drain();
      end

      repeat (LATENCY + 4) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
